/* rtl/bts_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bts_pkg: shared types and constants for the bounded tagged stack unit
// Widths, operation and status codes, config and result structs, and the
// small index helpers used by the engine and the top level.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Store geometry
    localparam int STORE_WORDS   = 4096;
    localparam int TAG_BITS      = 4;
    localparam int ADDR_BITS     = $clog2(STORE_WORDS);

    // Fixed field widths
    localparam int PTR_BITS      = 13;
    localparam int ADDR_OUT_BITS = 12;
    localparam int TAG_OUT_BITS  = 4;
    localparam int VALUE_BITS    = 64;
    localparam int CNT_BITS      = 32;
    localparam int KIND_BITS     = 2;
    localparam int STATUS_BITS   = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 13;
    localparam int RAM_WIDTH     = VALUE_BITS + TAG_BITS;

    // Stream beat widths (padded to whole bytes)
    localparam int S_TDATA_BITS  = 72;
    localparam int M_TDATA_BITS  = 176;
    localparam int M_USED_BITS   = ADDR_OUT_BITS + VALUE_BITS + TAG_OUT_BITS
                                   + 2 * PTR_BITS + 2 * CNT_BITS;

    localparam logic [PTR_BITS-1:0] BASE_RESET = PTR_BITS'(4096);
    localparam logic [PTR_BITS-1:0] CAP_RESET  = PTR_BITS'(4096);
    localparam logic [CNT_BITS-1:0] CNT_MAX    = {CNT_BITS{1'b1}};

    typedef enum logic [KIND_BITS-1:0] {
        KIND_PUSH  = 2'd0,
        KIND_POP   = 2'd1,
        KIND_CLEAR = 2'd2
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_OVERFLOW  = 2'd1,
        STATUS_DEPTH     = 2'd2,
        STATUS_UNDERFLOW = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_BASE   = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_CAP_ON = 2'd2,
        CFG_CAP    = 2'd3
    } cfg_index_t;

    // Register file view handed to the engine
    typedef struct packed {
        logic [PTR_BITS-1:0]      base;
        logic [ADDR_OUT_BITS-1:0] limit;
        logic                     cap_on;
        logic [PTR_BITS-1:0]      cap;
        logic                     base_wr;
        logic [PTR_BITS-1:0]      base_wr_data;
    } cfg_t;

    // Result held by the engine until the output register takes it
    typedef struct packed {
        logic                     valid;
        status_t                  status;
        logic [ADDR_OUT_BITS-1:0] addr;
        logic                     is_pop;
        logic [PTR_BITS-1:0]      depth;
        logic [PTR_BITS-1:0]      peak;
        logic [CNT_BITS-1:0]      push_cnt;
        logic [CNT_BITS-1:0]      pop_cnt;
    } res_t;

    // Store access request
    typedef struct packed {
        logic                 en;
        logic                 we;
        logic [ADDR_BITS-1:0] addr;
        logic [RAM_WIDTH-1:0] wdata;
    } ram_req_t;

    // Pointer modulo store size
    function automatic logic [ADDR_BITS-1:0] ptr_index(input logic [PTR_BITS-1:0] ptr);
        logic [ADDR_BITS+PTR_BITS-1:0] w;
        w = {{ADDR_BITS{1'b0}}, ptr};
        return w[ADDR_BITS-1:0];
    endfunction

    // Store index as reported in the 12-bit address field
    function automatic logic [ADDR_OUT_BITS-1:0] addr_report(input logic [ADDR_BITS-1:0] idx);
        logic [ADDR_BITS+ADDR_OUT_BITS-1:0] w;
        w = {{ADDR_OUT_BITS{1'b0}}, idx};
        return w[ADDR_OUT_BITS-1:0];
    endfunction

    function automatic logic [TAG_BITS-1:0] tag_keep(input logic [TAG_OUT_BITS-1:0] tag);
        logic [TAG_BITS+TAG_OUT_BITS-1:0] w;
        w = {{TAG_BITS{1'b0}}, tag};
        return w[TAG_BITS-1:0];
    endfunction

    function automatic logic [TAG_OUT_BITS-1:0] tag_report(input logic [TAG_BITS-1:0] tag);
        logic [TAG_BITS+TAG_OUT_BITS-1:0] w;
        w = {{TAG_OUT_BITS{1'b0}}, tag};
        return w[TAG_OUT_BITS-1:0];
    endfunction

    // Depth for a pointer: zero at or above the base
    function automatic logic [PTR_BITS-1:0] depth_at(input logic [PTR_BITS-1:0] ptr,
                                                     input logic [PTR_BITS-1:0] base);
        return (ptr < base) ? (base - ptr) : '0;
    endfunction

endpackage
`default_nettype wire

/* rtl/bounded_tagged_stack_unit_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_tagged_stack_unit_top: bounded stack of tagged 64-bit words
// Downward-growing stack with limit, depth cap and statistics, store in RAM.
//
//   channel   dir  handshake            payload
//   s_*       in   s_tvalid/s_tready    tuser kind, tdata value and tag
//   m_*       out  m_tvalid/m_tready    tuser status, tdata result fields
//   cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One beat per cycle while the output drains: each beat is decided in its
// accept cycle, and the single-port store registers a pop's read data on the
// same edge that loads the result register. Result register plus output
// register give two beats of slack; s_tready drops only when both are full.
// Reset is synchronous; the store has no clearing pass and is undefined
// until written. cfg_ready is always high.
// ----------------------------------------------------------------------------
module bounded_tagged_stack_unit_top (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // tuser: kind[1:0]
    // tdata: push_value[63:0], push_tag[67:64], zero pad[71:68]
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [bts_pkg::S_TDATA_BITS-1:0]   s_tdata,
    input  wire logic [bts_pkg::KIND_BITS-1:0]      s_tuser,
    // tuser: status[1:0]
    // tdata: word_address[11:0], pop_value[75:12], pop_tag[79:76],
    //        current_depth[92:80], peak_depth[105:93], push_count[137:106],
    //        pop_count[169:138], zero pad[175:170]
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [bts_pkg::M_TDATA_BITS-1:0]        m_tdata,
    output logic [bts_pkg::STATUS_BITS-1:0]         m_tuser,
    // configuration writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [bts_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  wire logic [bts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    bts_pkg::cfg_t     cfg;
    bts_pkg::res_t     res;
    bts_pkg::ram_req_t ram_req;
    logic [bts_pkg::RAM_WIDTH-1:0] ram_rdata;

    logic in_accept;
    logic res_take;

    logic                                 out_valid_reg;
    bts_pkg::status_t                     out_status_reg;
    logic [bts_pkg::ADDR_OUT_BITS-1:0]    out_addr_reg;
    logic [bts_pkg::VALUE_BITS-1:0]       out_value_reg;
    logic [bts_pkg::TAG_OUT_BITS-1:0]     out_tag_reg;
    logic [bts_pkg::PTR_BITS-1:0]         out_depth_reg;
    logic [bts_pkg::PTR_BITS-1:0]         out_peak_reg;
    logic [bts_pkg::CNT_BITS-1:0]         out_push_reg;
    logic [bts_pkg::CNT_BITS-1:0]         out_pop_reg;

    bts_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bts_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_accept (in_accept),
        .in_kind   (s_tuser),
        .in_value  (s_tdata[bts_pkg::VALUE_BITS-1:0]),
        .in_tag    (s_tdata[bts_pkg::VALUE_BITS +: bts_pkg::TAG_OUT_BITS]),
        .res_take  (res_take),
        .res       (res),
        .ram_req   (ram_req)
    );

    bts_ram #(
        .DEPTH (bts_pkg::STORE_WORDS),
        .WIDTH (bts_pkg::RAM_WIDTH)
    ) u_ram (
        .clk   (aclk),
        .en    (ram_req.en),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // Handshakes: result moves when the output register is free or draining
    assign res_take  = res.valid && (!out_valid_reg || m_tready);
    assign s_tready  = !res.valid || res_take;
    assign in_accept = s_tvalid && s_tready;

    // Output register: valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_take) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register: payload, pop data straight from the store
    always_ff @(posedge aclk) begin
        if (res_take) begin
            out_status_reg <= res.status;
            out_addr_reg   <= res.addr;
            out_value_reg  <= res.is_pop ? ram_rdata[bts_pkg::VALUE_BITS-1:0] : '0;
            out_tag_reg    <= res.is_pop
                ? bts_pkg::tag_report(ram_rdata[bts_pkg::VALUE_BITS +: bts_pkg::TAG_BITS])
                : '0;
            out_depth_reg  <= res.depth;
            out_peak_reg   <= res.peak;
            out_push_reg   <= res.push_cnt;
            out_pop_reg    <= res.pop_cnt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {{(bts_pkg::M_TDATA_BITS - bts_pkg::M_USED_BITS){1'b0}},
                       out_pop_reg, out_push_reg, out_peak_reg, out_depth_reg,
                       out_tag_reg, out_value_reg, out_addr_reg};

    // Checks
    a_accept_loads_result : assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> res.valid)
        else $error("accepted beat did not reach the result register");

    a_result_held : assert property (@(posedge aclk) disable iff (!aresetn)
        (res.valid && !res_take) |=> (res.valid && $stable(res.addr) && $stable(res.status)))
        else $error("waiting result changed before it was taken");

    a_refused_is_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != bts_pkg::STATUS_OK)) |->
        (out_addr_reg == '0 && out_value_reg == '0 && out_tag_reg == '0))
        else $error("refused beat carries address or pop data");

    a_reset_clears_out : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule
`default_nettype wire

/* rtl/bts_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bts_ram: single-port synchronous RAM
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
module bts_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 68
) (
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, or registered read
    always_ff @(posedge clk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata <= mem[addr];
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/bts_cfg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bts_cfg: configuration registers
// Base, limit, depth cap enable and depth cap; flags a base write so the
// engine can reload the stack pointer.
// ----------------------------------------------------------------------------
module bts_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [bts_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [bts_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output bts_pkg::cfg_t                          cfg
);

    logic [bts_pkg::PTR_BITS-1:0]      base_reg;
    logic [bts_pkg::ADDR_OUT_BITS-1:0] limit_reg;
    logic                              cap_on_reg;
    logic [bts_pkg::PTR_BITS-1:0]      cap_reg;
    logic                              wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid && cfg_ready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg   <= bts_pkg::BASE_RESET;
            limit_reg  <= '0;
            cap_on_reg <= 1'b0;
            cap_reg    <= bts_pkg::CAP_RESET;
        end else if (wr) begin
            unique case (bts_pkg::cfg_index_t'(cfg_index))
                bts_pkg::CFG_BASE:   base_reg   <= cfg_data[bts_pkg::PTR_BITS-1:0];
                bts_pkg::CFG_LIMIT:  limit_reg  <= cfg_data[bts_pkg::ADDR_OUT_BITS-1:0];
                bts_pkg::CFG_CAP_ON: cap_on_reg <= cfg_data[0];
                bts_pkg::CFG_CAP:    cap_reg    <= cfg_data[bts_pkg::PTR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.base         = base_reg;
        cfg.limit        = limit_reg;
        cfg.cap_on       = cap_on_reg;
        cfg.cap          = cap_reg;
        cfg.base_wr      = wr && (bts_pkg::cfg_index_t'(cfg_index) == bts_pkg::CFG_BASE);
        cfg.base_wr_data = cfg_data[bts_pkg::PTR_BITS-1:0];
    end

endmodule
`default_nettype wire

/* rtl/bts_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bts_engine: stack pointer, limit checks, statistics and result register
// Decides each beat in its accept cycle, issues the store write or read, and
// holds the result until the output stage takes it.
// ----------------------------------------------------------------------------
module bts_engine (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire bts_pkg::cfg_t                      cfg,
    input  wire logic                               in_accept,
    input  wire logic [bts_pkg::KIND_BITS-1:0]      in_kind,
    input  wire logic [bts_pkg::VALUE_BITS-1:0]     in_value,
    input  wire logic [bts_pkg::TAG_OUT_BITS-1:0]   in_tag,
    input  wire logic                               res_take,
    output bts_pkg::res_t                           res,
    output bts_pkg::ram_req_t                       ram_req
);

    logic [bts_pkg::PTR_BITS-1:0] sp_reg, sp_next;
    logic [bts_pkg::PTR_BITS-1:0] peak_reg, peak_next;
    logic [bts_pkg::CNT_BITS-1:0] push_cnt_reg, push_cnt_next;
    logic [bts_pkg::CNT_BITS-1:0] pop_cnt_reg, pop_cnt_next;
    bts_pkg::res_t                res_reg, res_next;

    logic [bts_pkg::PTR_BITS-1:0]  np;
    logic [bts_pkg::PTR_BITS-1:0]  np_depth;
    logic [bts_pkg::ADDR_BITS-1:0] push_idx;
    logic [bts_pkg::ADDR_BITS-1:0] pop_idx;
    logic                          at_limit;
    logic                          cap_hit;
    logic                          push_ok;
    logic                          pop_ok;
    bts_pkg::status_t              status;
    logic [bts_pkg::ADDR_OUT_BITS-1:0] addr_out;

    // Checks on the current pointer
    always_comb begin
        np       = sp_reg - 1'b1;
        np_depth = bts_pkg::depth_at(np, cfg.base);
        push_idx = bts_pkg::ptr_index(np);
        pop_idx  = bts_pkg::ptr_index(sp_reg);
        at_limit = sp_reg <= {1'b0, cfg.limit};
        cap_hit  = cfg.cap_on && (np_depth > cfg.cap);
    end

    // Next state and result
    always_comb begin
        sp_next       = sp_reg;
        peak_next     = peak_reg;
        push_cnt_next = push_cnt_reg;
        pop_cnt_next  = pop_cnt_reg;
        push_ok       = 1'b0;
        pop_ok        = 1'b0;
        status        = bts_pkg::STATUS_OK;
        addr_out      = '0;

        case (bts_pkg::kind_t'(in_kind))
            bts_pkg::KIND_PUSH: begin
                if (at_limit) begin
                    status = bts_pkg::STATUS_OVERFLOW;
                end else if (cap_hit) begin
                    status = bts_pkg::STATUS_DEPTH;
                end else begin
                    push_ok  = 1'b1;
                    sp_next  = np;
                    addr_out = bts_pkg::addr_report(push_idx);
                    if (np_depth > peak_reg) begin
                        peak_next = np_depth;
                    end
                    if (push_cnt_reg != bts_pkg::CNT_MAX) begin
                        push_cnt_next = push_cnt_reg + 1'b1;
                    end
                end
            end
            bts_pkg::KIND_POP: begin
                if (sp_reg >= cfg.base) begin
                    status = bts_pkg::STATUS_UNDERFLOW;
                end else begin
                    pop_ok   = 1'b1;
                    sp_next  = sp_reg + 1'b1;
                    addr_out = bts_pkg::addr_report(pop_idx);
                    if (pop_cnt_reg != bts_pkg::CNT_MAX) begin
                        pop_cnt_next = pop_cnt_reg + 1'b1;
                    end
                end
            end
            bts_pkg::KIND_CLEAR: begin
                peak_next     = '0;
                push_cnt_next = '0;
                pop_cnt_next  = '0;
            end
            default: ;
        endcase

        res_next.valid    = 1'b1;
        res_next.status   = status;
        res_next.addr     = addr_out;
        res_next.is_pop   = pop_ok;
        res_next.depth    = bts_pkg::depth_at(sp_next, cfg.base);
        res_next.peak     = peak_next;
        res_next.push_cnt = push_cnt_next;
        res_next.pop_cnt  = pop_cnt_next;
    end

    // Store access: push writes at the new pointer, pop reads at the old one
    always_comb begin
        ram_req.en    = in_accept && (push_ok || pop_ok);
        ram_req.we    = push_ok;
        ram_req.addr  = push_ok ? push_idx : pop_idx;
        ram_req.wdata = {bts_pkg::tag_keep(in_tag), in_value};
    end

    // Pointer and statistics
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg       <= bts_pkg::BASE_RESET;
            peak_reg     <= '0;
            push_cnt_reg <= '0;
            pop_cnt_reg  <= '0;
        end else if (cfg.base_wr) begin
            sp_reg <= cfg.base_wr_data;
        end else if (in_accept) begin
            sp_reg       <= sp_next;
            peak_reg     <= peak_next;
            push_cnt_reg <= push_cnt_next;
            pop_cnt_reg  <= pop_cnt_next;
        end
    end

    // Result register: valid flag under reset, payload loaded with each beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_reg.valid <= 1'b0;
        end else if (in_accept) begin
            res_reg.valid <= 1'b1;
        end else if (res_take) begin
            res_reg.valid <= 1'b0;
        end
        if (in_accept) begin
            res_reg.status   <= res_next.status;
            res_reg.addr     <= res_next.addr;
            res_reg.is_pop   <= res_next.is_pop;
            res_reg.depth    <= res_next.depth;
            res_reg.peak     <= res_next.peak;
            res_reg.push_cnt <= res_next.push_cnt;
            res_reg.pop_cnt  <= res_next.pop_cnt;
        end
    end

    assign res = res_reg;

endmodule
`default_nettype wire
